// ----- rtl/core/spq_pkg.sv -----
// Shared types and codes for the sorted priority queue.
`default_nettype none

package spq_pkg;

    localparam int MODE_BITS   = 2;
    localparam int STATUS_BITS = 2;

    localparam logic [MODE_BITS-1:0] MODE_ENQUEUE = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_DEQUEUE = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_CLEAR   = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_NOP     = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    // Shift commands broadcast to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
    } t_spq_ctrl;

endpackage

`default_nettype wire

// ----- rtl/core/spq_cell.sv -----
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
`default_nettype none

module spq_cell #(
    parameter int DATA_BITS     = 32,
    parameter int PRIORITY_BITS = 16
) (
    input  wire                       i_clk,
    input  wire spq_pkg::t_spq_ctrl   i_ctrl,
    input  wire                       i_occupied,
    input  wire  [DATA_BITS-1:0]      i_new_data,
    input  wire  [PRIORITY_BITS-1:0]  i_new_prio,
    input  wire                       i_left_sel,
    input  wire  [DATA_BITS-1:0]      i_left_data,
    input  wire  [PRIORITY_BITS-1:0]  i_left_prio,
    input  wire  [DATA_BITS-1:0]      i_right_data,
    input  wire  [PRIORITY_BITS-1:0]  i_right_prio,
    output logic                      o_sel,
    output logic [DATA_BITS-1:0]      o_data,
    output logic [PRIORITY_BITS-1:0]  o_prio
);
    import spq_pkg::*;

    logic [DATA_BITS-1:0]     r_data;
    logic [PRIORITY_BITS-1:0] r_prio;
    logic [DATA_BITS-1:0]     n_data;
    logic [PRIORITY_BITS-1:0] n_prio;

    // This slot lies at or after the insert point: it is free, or holds a
    // strictly larger priority, so a new entry goes after equals.
    assign o_sel = !i_occupied || (i_new_prio < r_prio);

    always_comb begin
        n_data = r_data;
        n_prio = r_prio;
        if (i_ctrl.push && o_sel) begin
            if (i_left_sel) begin
                n_data = i_left_data;
                n_prio = i_left_prio;
            end else begin
                n_data = i_new_data;
                n_prio = i_new_prio;
            end
        end else if (i_ctrl.pop) begin
            n_data = i_right_data;
            n_prio = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_prio <= n_prio;
    end

    assign o_data = r_data;
    assign o_prio = r_prio;

endmodule

`default_nettype wire

// ----- rtl/core/sorted_priority_queue_top.sv -----
// Top level of the stable sorted priority queue built as a chain of slots.
`default_nettype none

// The queue holds up to DEPTH entries in a row of slots kept in ascending
// priority order, head in slot 0; an enqueued entry goes after all entries
// of equal priority. All slots compare the incoming priority at once and
// shift left or right in the same cycle; for every operation (enqueue,
// dequeue, clear, or the no-op mode three) the result beat appears on the
// output register the cycle after the input beat is accepted. The input
// is ready whenever the output register is empty or being taken, so with
// the output side always ready the block takes one beat per cycle. The
// slot contents have no reset; the held count alone decides which slots
// are live, so the block is ready right after reset.
module sorted_priority_queue_top #(
    parameter int DEPTH         = 16,
    parameter int DATA_BITS     = 32,
    parameter int PRIORITY_BITS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire  [spq_pkg::MODE_BITS-1:0]    i_mode,
    input  wire  signed [DATA_BITS-1:0]      i_in_info,
    input  wire  [PRIORITY_BITS-1:0]         i_in_priority,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic [spq_pkg::STATUS_BITS-1:0]  o_status,
    output logic signed [DATA_BITS-1:0]      o_out_info,
    output logic [PRIORITY_BITS-1:0]         o_out_priority,
    output logic [$clog2(DEPTH+1)-1:0]       o_entry_count,
    output logic                             o_is_empty
);
    import spq_pkg::*;

    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

    logic                     in_beat;
    logic                     is_full;
    logic                     is_none;
    t_spq_ctrl                ctrl;

    logic [CNT_BITS-1:0]      r_count;
    logic [CNT_BITS-1:0]      n_count;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [STATUS_BITS-1:0]   r_status;
    logic [STATUS_BITS-1:0]   n_status;
    logic [DATA_BITS-1:0]     r_out_data;
    logic [DATA_BITS-1:0]     n_out_data;
    logic [PRIORITY_BITS-1:0] r_out_prio;
    logic [PRIORITY_BITS-1:0] n_out_prio;

    logic [DEPTH-1:0]         occupied;
    logic [DEPTH-1:0]         sel;
    logic [DATA_BITS-1:0]     cell_data [DEPTH];
    logic [PRIORITY_BITS-1:0] cell_prio [DEPTH];

    assign o_ready = !r_out_valid || i_ready;
    assign in_beat = i_valid && o_ready;
    assign is_full = (r_count == FULL_COUNT);
    assign is_none = (r_count == '0);

    assign ctrl.push = in_beat && (i_mode == MODE_ENQUEUE) && !is_full;
    assign ctrl.pop  = in_beat && (i_mode == MODE_DEQUEUE) && !is_none;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic                     left_sel;
        logic [DATA_BITS-1:0]     left_data;
        logic [PRIORITY_BITS-1:0] left_prio;
        logic [DATA_BITS-1:0]     right_data;
        logic [PRIORITY_BITS-1:0] right_prio;

        assign occupied[k] = (CNT_BITS'(k) < r_count);

        if (k == 0) begin : g_head
            assign left_sel  = 1'b0;
            assign left_data = '0;
            assign left_prio = '0;
        end else begin : g_body
            assign left_sel  = sel[k-1];
            assign left_data = cell_data[k-1];
            assign left_prio = cell_prio[k-1];
        end

        if (k == DEPTH - 1) begin : g_tail
            assign right_data = '0;
            assign right_prio = '0;
        end else begin : g_inner
            assign right_data = cell_data[k+1];
            assign right_prio = cell_prio[k+1];
        end

        spq_cell #(
            .DATA_BITS     (DATA_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_occupied   (occupied[k]),
            .i_new_data   ($unsigned(i_in_info)),
            .i_new_prio   (i_in_priority),
            .i_left_sel   (left_sel),
            .i_left_data  (left_data),
            .i_left_prio  (left_prio),
            .i_right_data (right_data),
            .i_right_prio (right_prio),
            .o_sel        (sel[k]),
            .o_data       (cell_data[k]),
            .o_prio       (cell_prio[k])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_status    = r_status;
        n_out_data  = r_out_data;
        n_out_prio  = r_out_prio;
        n_out_valid = r_out_valid && !i_ready;
        if (in_beat) begin
            n_out_valid = 1'b1;
            n_status    = ST_DONE;
            n_out_data  = '0;
            n_out_prio  = '0;
            unique case (i_mode)
                MODE_ENQUEUE: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
                MODE_DEQUEUE: begin
                    if (is_none) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_count    = r_count - 1'b1;
                        n_out_data = cell_data[0];
                        n_out_prio = cell_prio[0];
                    end
                end
                MODE_CLEAR: begin
                    n_count = '0;
                end
                MODE_NOP: begin
                    n_count = r_count;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_out_data <= n_out_data;
        r_out_prio <= n_out_prio;
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_out_info     = $signed(r_out_data);
    assign o_out_priority = r_out_prio;
    assign o_entry_count  = r_count;
    assign o_is_empty     = (r_count == '0);

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("held count exceeds the queue depth");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (r_count == FULL_COUNT))
        else $error("full status reported while the queue has room");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.pop |=> (r_count == $past(r_count) - 1'b1))
        else $error("dequeue did not remove exactly one entry");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.push |=> (r_count == $past(r_count) + 1'b1))
        else $error("enqueue did not add exactly one entry");
`endif

endmodule

`default_nettype wire
